// ----- rtl/core/dhm_pkg.sv -----
package dhm_pkg;

  // Width of every field and register on the ports.
  localparam int unsigned FIELD_W = 32;

  // Reset value of the modulus register.
  localparam logic [FIELD_W-1:0] MOD_RESET = 32'd3877;

  // Configuration register indexes.
  localparam logic REG_MODULUS  = 1'b0;
  localparam logic REG_EXPONENT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL_R,
    ST_MUL_S,
    ST_DONE
  } state_e;

endpackage

// ----- rtl/core/dhm_modstep.sv -----
// One shift-add step of a modular product: (2 * acc + addend) mod modulus.
// Both acc and addend are below the modulus, so the sum is below three times it.
module dhm_modstep #(
  parameter int unsigned WIDTH = 32
) (
  input  logic [WIDTH-1:0] acc_i,
  input  logic [WIDTH-1:0] addend_i,
  input  logic [WIDTH-1:0] mod_i,
  output logic [WIDTH-1:0] res_o
);

  logic [WIDTH+1:0] sum;
  logic [WIDTH+1:0] mod1;
  logic [WIDTH+1:0] mod2;
  logic [WIDTH+1:0] sub1;
  logic [WIDTH+1:0] sub2;

  always_comb begin
    sum  = {1'b0, acc_i, 1'b0} + {2'b00, addend_i};
    mod1 = {2'b00, mod_i};
    mod2 = {1'b0, mod_i, 1'b0};
    sub1 = sum - mod1;
    sub2 = sum - mod2;
    if (sum >= mod2) begin
      res_o = sub2[WIDTH-1:0];
    end else if (sum >= mod1) begin
      res_o = sub1[WIDTH-1:0];
    end else begin
      res_o = sum[WIDTH-1:0];
    end
  end

endmodule

// ----- rtl/core/diffie_hellman_modexp.sv -----
// Modular exponentiation for a Diffie-Hellman exchange. Each base taken on the
// input channel returns one result, base ^ private_exponent mod modulus, on the
// output channel; feed the public generator to get this party's public token or
// a peer's token to get the shared key. The modulus (register 0, reset 3877) and
// the private exponent (register 1, reset 0) are written through the plain write
// port; the user must write them only while the block is idle, and the block
// itself does not enforce this. Operands are taken in their low WIDTH bits. A
// modulus of zero or one gives 0, and an exponent of zero gives 1. The work is
// done by a single shift-add modular step unit, one multiplier bit per cycle,
// under a small sequencer: the base is first reduced, then each of the WIDTH
// exponent bits costs one squaring plus, when the bit is set, one more
// multiplication. The block takes one base at a time; the finished result sits
// in an output register, so the next base is accepted while the previous
// transaction waits to be taken.
module diffie_hellman_modexp #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [dhm_pkg::FIELD_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dhm_pkg::FIELD_W-1:0] base_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [dhm_pkg::FIELD_W-1:0] power_mod_o
);

  localparam int unsigned IDX_W = $clog2(WIDTH);
  localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(WIDTH - 1);

  // Configuration registers.
  logic [WIDTH-1:0] modulus_q;
  logic [WIDTH-1:0] exponent_q;

  // Sequencer and datapath registers.
  dhm_pkg::state_e state_q, state_d;
  logic [WIDTH-1:0] acc_q, acc_d;      // running partial product
  logic [WIDTH-1:0] res_q, res_d;      // running power
  logic [WIDTH-1:0] sq_q, sq_d;        // base, then its repeated squares
  logic [IDX_W-1:0] cnt_q, cnt_d;      // multiplier bit, scanned from the top
  logic [IDX_W-1:0] ebit_q, ebit_d;    // exponent bit being handled
  logic             out_valid_q, out_valid_d;
  logic [dhm_pkg::FIELD_W-1:0] out_q, out_d;

  logic [WIDTH-1:0] addend;
  logic [WIDTH-1:0] step;
  logic [IDX_W-1:0] ebit_nx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= WIDTH'(dhm_pkg::MOD_RESET);
      exponent_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dhm_pkg::REG_MODULUS:  modulus_q  <= WIDTH'(cfg_wdata_i);
        dhm_pkg::REG_EXPONENT: exponent_q <= WIDTH'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // The one arithmetic unit, shared by the base reduction and every product.
  dhm_modstep #(
    .WIDTH(WIDTH)
  ) u_modstep (
    .acc_i   (acc_q),
    .addend_i(addend),
    .mod_i   (modulus_q),
    .res_o   (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dhm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      ebit_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      ebit_q      <= ebit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    res_q <= res_d;
    sq_q  <= sq_d;
    out_q <= out_d;
  end

  assign ebit_nx = ebit_q + IDX_W'(1);

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    res_d       = res_q;
    sq_d        = sq_q;
    cnt_d       = cnt_q;
    ebit_d      = ebit_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    addend      = '0;

    case (state_q)
      dhm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          sq_d   = WIDTH'(base_i);
          acc_d  = '0;
          cnt_d  = LAST_BIT;
          ebit_d = '0;
          if (modulus_q < WIDTH'(2)) begin
            res_d   = '0;
            state_d = dhm_pkg::ST_DONE;
          end else begin
            res_d   = WIDTH'(1);
            state_d = dhm_pkg::ST_REDUCE;
          end
        end
      end

      // Long remainder of the base: shift in one base bit per cycle.
      dhm_pkg::ST_REDUCE: begin
        addend = WIDTH'(sq_q[cnt_q]);
        acc_d  = step;
        cnt_d  = cnt_q - IDX_W'(1);
        if (cnt_q == '0) begin
          sq_d    = step;
          acc_d   = '0;
          cnt_d   = LAST_BIT;
          state_d = exponent_q[0] ? dhm_pkg::ST_MUL_R : dhm_pkg::ST_MUL_S;
        end
      end

      // Power times current square, scanning the square's bits.
      dhm_pkg::ST_MUL_R: begin
        addend = sq_q[cnt_q] ? res_q : '0;
        acc_d  = step;
        cnt_d  = cnt_q - IDX_W'(1);
        if (cnt_q == '0) begin
          res_d   = step;
          acc_d   = '0;
          cnt_d   = LAST_BIT;
          state_d = dhm_pkg::ST_MUL_S;
        end
      end

      // Square the current square, then move to the next exponent bit or finish.
      dhm_pkg::ST_MUL_S: begin
        addend = sq_q[cnt_q] ? sq_q : '0;
        acc_d  = step;
        cnt_d  = cnt_q - IDX_W'(1);
        if (cnt_q == '0) begin
          sq_d  = step;
          acc_d = '0;
          cnt_d = LAST_BIT;
          if (ebit_q == LAST_BIT) begin
            state_d = dhm_pkg::ST_DONE;
          end else begin
            ebit_d  = ebit_nx;
            state_d = exponent_q[ebit_nx] ? dhm_pkg::ST_MUL_R : dhm_pkg::ST_MUL_S;
          end
        end
      end

      // Hand the power to the output register once it is free.
      dhm_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = dhm_pkg::FIELD_W'(res_q);
          state_d     = dhm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = dhm_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == dhm_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign power_mod_o = out_q;

endmodule

// ----- rtl/core/dhm_checker.sv -----
module dhm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [dhm_pkg::FIELD_W-1:0] power_mod_o
);

  // The block works on one base at a time, so it is busy right after a transaction.
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o
  ) else $error("input accepted again in the cycle after a transaction");

  // No result can come out in the cycle right after a base is taken.
  a_no_instant_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !$rose(out_valid_o)
  ) else $error("result appeared one cycle after a base was taken");

  // A stalled result holds its value.
  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(power_mod_o))
  ) else $error("stalled result dropped or changed");

endmodule

bind diffie_hellman_modexp dhm_checker u_dhm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .power_mod_o(power_mod_o)
);

// ----- tb/sv/diffie_hellman_modexp_test.sv -----
module diffie_hellman_modexp_test;

  // A quiet stretch is any run of cycles in which neither channel completes a
  // transaction. The slowest legal stretch is a long sender hold, a full
  // exponentiation and a long receiver stall back to back. The limit allows
  // several times that.
  localparam int QUIET_LIMIT = 40000;
  // Cycles to keep watching the output once nothing is outstanding.
  localparam int TAIL_CYCLES = 2100;
  localparam int SEGMENTS = 8;
  localparam int SEGMENT_ITEMS = 32;
  localparam int DIR_N = 23;

  // One row of the directed table. When known is set, power holds the value
  // that can be read straight off the arithmetic; otherwise the row is
  // checked against the predictor.
  typedef struct packed {
    logic [dhm_pkg::FIELD_W-1:0] modulus;
    logic [dhm_pkg::FIELD_W-1:0] exponent;
    logic [dhm_pkg::FIELD_W-1:0] base;
    logic                        known;
    logic [dhm_pkg::FIELD_W-1:0] power;
  } dir_row_t;

  localparam logic [dhm_pkg::FIELD_W-1:0] ALL_ONES = '1;

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // Reset values: modulus 3877 and exponent zero, so every base gives 1.
    '{32'd3877, 32'd0, 32'd5, 1'b1, 32'd1},
    '{32'd3877, 32'd0, 32'd0, 1'b1, 32'd1},
    '{32'd3877, 32'd0, ALL_ONES, 1'b1, 32'd1},
    // Exponent one returns the base reduced by the modulus.
    '{32'd3877, 32'd1, 32'd3876, 1'b1, 32'd3876},
    '{32'd3877, 32'd1, 32'd3877, 1'b1, 32'd0},
    '{32'd3877, 32'd1, 32'd3878, 1'b1, 32'd1},
    '{32'd3877, 32'd1, ALL_ONES, 1'b0, 32'd0},
    // Minus one squared is one.
    '{32'd3877, 32'd2, 32'd3876, 1'b1, 32'd1},
    '{32'd3877, 32'd12345, 32'd2, 1'b0, 32'd0},
    // A modulus of zero or one always answers zero, even for exponent zero.
    '{32'd0, 32'd1, 32'd5, 1'b1, 32'd0},
    '{32'd0, 32'd0, 32'd5, 1'b1, 32'd0},
    '{32'd1, 32'd0, 32'd7, 1'b1, 32'd0},
    '{32'd1, ALL_ONES, ALL_ONES, 1'b1, 32'd0},
    // Smallest meaningful modulus.
    '{32'd2, 32'd0, 32'd0, 1'b1, 32'd1},
    '{32'd2, ALL_ONES, 32'd3, 1'b1, 32'd1},
    '{32'd2, ALL_ONES, 32'hFFFF_FFFE, 1'b1, 32'd0},
    // Largest modulus with the largest exponent, which is odd.
    '{ALL_ONES, ALL_ONES, 32'd0, 1'b1, 32'd0},
    '{ALL_ONES, ALL_ONES, 32'd1, 1'b1, 32'd1},
    '{ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, 32'd0},
    '{ALL_ONES, ALL_ONES, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE},
    // The largest 32-bit prime: two to the power p-1 is one.
    '{32'hFFFF_FFFB, 32'hFFFF_FFFA, 32'd2, 1'b1, 32'd1},
    '{32'hFFFF_FFFB, 32'hAAAA_AAAA, 32'hDEAD_BEEF, 1'b0, 32'd0},
    '{32'hFFFF_FFFB, 32'h5555_5555, 32'h1234_5678, 1'b0, 32'd0}
  };

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic                        cfg_idx = dhm_pkg::REG_MODULUS;
  logic [dhm_pkg::FIELD_W-1:0] cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready_o;
  logic [dhm_pkg::FIELD_W-1:0] base = '0;
  logic                        out_valid_o;
  logic                        out_ready = 1'b0;
  logic [dhm_pkg::FIELD_W-1:0] power_mod_o;

  // Register copies as the block holds them, starting from their reset values.
  logic [dhm_pkg::FIELD_W-1:0] cur_mod = dhm_pkg::MOD_RESET;
  logic [dhm_pkg::FIELD_W-1:0] cur_exp = '0;

  // Expected powers, oldest first, one per accepted base.
  logic [dhm_pkg::FIELD_W-1:0] want_power_q [$];
  logic [dhm_pkg::FIELD_W-1:0] oldest_power;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int bases_sent = 0;
  int results_seen = 0;
  int settings_used = 0;
  int fails = 0;
  int reports = 0;

  diffie_hellman_modexp u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .base_i      (base),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .power_mod_o (power_mod_o)
  );

  always #4 clk = ~clk;

  // Right-to-left square-and-multiply. Operands stay below the modulus, so each
  // 64-bit product is exact before it is reduced.
  function automatic logic [dhm_pkg::FIELD_W-1:0] power_mod_of(
    input logic [dhm_pkg::FIELD_W-1:0] b,
    input logic [dhm_pkg::FIELD_W-1:0] e,
    input logic [dhm_pkg::FIELD_W-1:0] m
  );
    logic [63:0] acc;
    logic [63:0] sq;
    if (m < 2) begin
      return '0;
    end
    acc = 64'd1;
    sq = 64'(b) % 64'(m);
    for (int i = 0; i < dhm_pkg::FIELD_W; i++) begin
      if (e[i]) begin
        acc = (acc * sq) % 64'(m);
      end
      sq = (sq * sq) % 64'(m);
    end
    return acc[dhm_pkg::FIELD_W-1:0];
  endfunction

  // Presents one base and returns at the edge where the transaction completes.
  // Valid is left high so that the next call can keep it up without a dip; the
  // caller lowers it when no base follows at once.
  task automatic send_base(
    input logic [dhm_pkg::FIELD_W-1:0] b,
    input logic                        known,
    input logic [dhm_pkg::FIELD_W-1:0] power
  );
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
      // Now and then hold back long enough for the block to go idle, so that
      // the next base arrives at a different point of the work.
      if ($urandom_range(15) == 0) begin
        repeat ($urandom_range(2200)) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    base <= b;
    do @(posedge clk); while (!in_ready_o);
    want_power_q.push_back(known ? power : power_mod_of(b, cur_exp, cur_mod));
    bases_sent++;
  endtask

  // Lets every outstanding result drain, then writes both registers. The
  // block always answers each base, so an empty store means it is idle.
  task automatic set_regs(
    input logic [dhm_pkg::FIELD_W-1:0] m,
    input logic [dhm_pkg::FIELD_W-1:0] e
  );
    in_valid <= 1'b0;
    while (want_power_q.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= dhm_pkg::REG_MODULUS;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_idx <= dhm_pkg::REG_EXPONENT;
    cfg_wdata <= e;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_mod = m;
    cur_exp = e;
    settings_used++;
  endtask

  // Output side: check each completed result transaction against the oldest
  // expectation, drive the receiver's stalls, and watch for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid_o && out_ready) begin
        results_seen++;
        if (want_power_q.size() == 0) begin
          fails++;
          if (reports < 10) begin
            $display("result %h with nothing outstanding", power_mod_o);
          end
          reports++;
        end else begin
          oldest_power = want_power_q.pop_front();
          if (power_mod_o !== oldest_power) begin
            fails++;
            if (reports < 10) begin
              $display("power_mod mismatch: expected %h, got %h", oldest_power, power_mod_o);
            end
            reports++;
          end
        end
      end

      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end

      // Short random stalls at the phase's rate, with a rare long one that lets
      // the next result finish while the current one is still held.
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (recv_stall_pct != 0 && $urandom_range(255) == 0) begin
        stall_left = $urandom_range(2200);
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end

      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    logic [dhm_pkg::FIELD_W-1:0] m;
    logic [dhm_pkg::FIELD_W-1:0] e;
    logic [dhm_pkg::FIELD_W-1:0] b;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: the first rows run on the reset values, and the registers
    // are rewritten only where a row asks for a different setting.
    for (int r = 0; r < DIR_N; r++) begin
      if (DIR_ROWS[r].modulus != cur_mod || DIR_ROWS[r].exponent != cur_exp) begin
        set_regs(DIR_ROWS[r].modulus, DIR_ROWS[r].exponent);
      end
      send_base(DIR_ROWS[r].base, DIR_ROWS[r].known, DIR_ROWS[r].power);
    end

    // Random part: each segment picks a register setting and an idling mode.
    // The modes cycle through no idling, a mostly idle sender, a mostly
    // stalling receiver, and both idling at a lower rate.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: begin
          m = ALL_ONES;
          e = ALL_ONES;
        end
        2: begin
          m = $urandom_range(255, 2);
          e = $urandom;
        end
        3: begin
          m = $urandom_range(1);
          e = $urandom;
        end
        4: begin
          m = $urandom | 32'd1;
          e = '0;
        end
        5: begin
          m = $urandom;
          e = $urandom_range(15);
        end
        6: begin
          m = 32'd2;
          e = $urandom;
        end
        default: begin
          m = $urandom;
          e = $urandom;
        end
      endcase
      set_regs(m, e);

      case (seg % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 81;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 81;
        end
        default: begin
          send_idle_pct = 32;
          recv_stall_pct = 32;
        end
      endcase

      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        // Half full-range bases, the rest right around the modulus and
        // at the ends of the field.
        case ($urandom_range(9))
          0: b = '0;
          1: b = ALL_ONES;
          2: b = cur_mod - 32'd1;
          3: b = cur_mod + $urandom_range(3);
          4: b = $urandom_range(15);
          default: b = $urandom;
        endcase
        send_base(b, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (want_power_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    fails += want_power_q.size();

    $display("run covered %0d bases under %0d register settings, %0d results checked",
             bases_sent, settings_used, results_seen);
    $display("idling modes: none, sender 81%%, receiver 81%%, both 32%%; %0d failures",
             fails);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/dhm_pkg.sv
rtl/core/dhm_modstep.sv
rtl/core/diffie_hellman_modexp.sv
rtl/core/dhm_checker.sv
tb/sv/diffie_hellman_modexp_test.sv
